// ===== hw/rtl/tkd_pkg.sv =====
`default_nettype none

package tkd_pkg;

  // byte values the parser looks for
  localparam logic [7:0] ESC_BYTE     = 8'h1B;
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;  // '['
  localparam logic [7:0] CHAR_O       = 8'h4F;  // 'O'
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;  // '~'
  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;  // '$'
  localparam logic [7:0] CHAR_CARET   = 8'h5E;  // '^'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'

  localparam int unsigned KEY_W   = 9;
  localparam int unsigned PARAM_W = 32;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_ESC2 = 2'd2,
    MODE_BODY = 2'd3
  } parse_mode_t;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SPECIAL = 2'd1,
    KIND_MOUSE   = 2'd2,
    KIND_UNKNOWN = 2'd3
  } result_kind_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    result_kind_t     kind;
  } result_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CHAR_TILDE) || (b == CHAR_DOLLAR) || (b == CHAR_CARET);
  endfunction

  // letter table: 'M' opens a mouse report, cursor and function letters map to keys
  function automatic result_t letter_lookup(input logic [7:0] b);
    result_t r;
    r.key_code = '0;
    r.kind     = KIND_SPECIAL;
    unique case (b)
      8'h4D: r.kind = KIND_MOUSE;      // 'M'
      8'h41: r.key_code = 9'd327;      // 'A'
      8'h42: r.key_code = 9'd335;      // 'B'
      8'h43: r.key_code = 9'd332;      // 'C'
      8'h44: r.key_code = 9'd330;      // 'D'
      8'h46: r.key_code = 9'd334;      // 'F'
      8'h48: r.key_code = 9'd326;      // 'H'
      8'h50: r.key_code = 9'd314;      // 'P'
      8'h51: r.key_code = 9'd315;      // 'Q'
      8'h52: r.key_code = 9'd316;      // 'R'
      8'h53: r.key_code = 9'd317;      // 'S'
      default: r.kind = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

  // numeric table for sequences closed by a terminator
  function automatic result_t number_lookup(input logic [PARAM_W-1:0] p);
    result_t r;
    r.key_code = '0;
    r.kind     = KIND_SPECIAL;
    unique case (p)
      32'd2:  r.key_code = 9'd326;
      32'd3:  r.key_code = 9'd338;
      32'd5:  r.key_code = 9'd328;
      32'd6:  r.key_code = 9'd336;
      32'd7:  r.key_code = 9'd334;
      32'd8:  r.key_code = 9'd326;
      32'd15: r.key_code = 9'd318;
      32'd17: r.key_code = 9'd319;
      32'd18: r.key_code = 9'd320;
      32'd19: r.key_code = 9'd321;
      32'd20: r.key_code = 9'd322;
      32'd21: r.key_code = 9'd323;
      32'd23: r.key_code = 9'd388;
      32'd24: r.key_code = 9'd389;
      default: r.kind = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/terminal_escape_key_decoder.sv =====
// Terminal escape key decoder. Raw terminal bytes enter on the s_ side, one item
// per byte; plain bytes come out as kind 0 with the byte as key code, escape
// sequences (ESC, optional second ESC, optional '[' or 'O', decimal parameter,
// then a letter or one of '~' '$' '^') come out as one item of kind 1 (special
// key), 2 (mouse report start) or 3 (unrecognized); bytes inside a sequence give
// no item. Sustained rate is one byte per clock while the output buffer has room:
// the parse state register closes its loop through a single decode stage. m_tvalid
// rises once the byte has passed the input register and then the result register;
// a two-entry output buffer keeps input flowing while a result waits.
`default_nettype none

module terminal_escape_key_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [8:0] key_code, [15:9] zero
  output logic [1:0]       m_tuser    // [1:0] result_kind
);
  import tkd_pkg::*;

  logic       in_valid;
  logic [7:0] in_data;
  logic       has_result;
  logic       buf_ready;
  logic       advance;
  result_t    dec_result;
  result_t    out_data;

  assign advance  = in_valid && (buf_ready || !has_result);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (in_valid && !advance) || (s_tvalid && s_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  tkd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .in_byte    (in_data),
    .has_result (has_result),
    .result     (dec_result)
  );

  tkd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && has_result),
    .push_data  (dec_result),
    .push_ready (buf_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tdata = {{(16-KEY_W){1'b0}}, out_data.key_code};
  assign m_tuser = out_data.kind;

endmodule

`default_nettype wire

// ===== hw/rtl/tkd_parser.sv =====
`default_nettype none

module tkd_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      in_byte,
  output logic                 has_result,
  output tkd_pkg::result_t     result
);
  import tkd_pkg::*;

  parse_mode_t        mode, mode_next;
  logic [PARAM_W-1:0] param, param_next;
  logic               semi, semi_next;
  logic [PARAM_W-1:0] param_fold;

  // param*10 + (byte - '0'), wrapping
  assign param_fold = (param << 3) + (param << 1)
                    + ({{(PARAM_W-8){1'b0}}, in_byte} - {{(PARAM_W-8){1'b0}}, CHAR_ZERO});

  // next state and result for the byte in the input register
  always_comb begin
    logic body;
    logic semi_tmp;
    mode_next  = mode;
    param_next = param;
    semi_next  = semi;
    has_result = 1'b0;
    result     = '{key_code: '0, kind: KIND_PLAIN};
    body       = 1'b0;
    semi_tmp   = semi;

    unique case (mode)
      MODE_IDLE: begin
        if (in_byte == ESC_BYTE) begin
          mode_next  = MODE_ESC;
          param_next = '0;
          semi_next  = 1'b0;
        end else begin
          has_result      = 1'b1;
          result.key_code = {1'b0, in_byte};
          result.kind     = KIND_PLAIN;
        end
      end
      MODE_ESC: begin
        if (in_byte == ESC_BYTE) begin
          mode_next = MODE_ESC2;
        end else if ((in_byte == CHAR_LBRACK) || (in_byte == CHAR_O)) begin
          mode_next = MODE_BODY;
        end else begin
          body = 1'b1;
        end
      end
      MODE_ESC2: begin
        if ((in_byte == CHAR_LBRACK) || (in_byte == CHAR_O)) begin
          mode_next = MODE_BODY;
        end else begin
          body = 1'b1;
        end
      end
      MODE_BODY: begin
        body = 1'b1;
      end
      default: begin
        body = 1'b1;
      end
    endcase

    // sequence body: terminator, letter, or parameter byte
    if (body) begin
      priority if (is_terminator(in_byte)) begin
        has_result = 1'b1;
        result     = number_lookup(param);
        mode_next  = MODE_IDLE;
        param_next = '0;
        semi_next  = 1'b0;
      end else if (is_letter(in_byte)) begin
        has_result = 1'b1;
        result     = letter_lookup(in_byte);
        mode_next  = MODE_IDLE;
        param_next = '0;
        semi_next  = 1'b0;
      end else begin
        semi_tmp  = semi || (in_byte == CHAR_SEMI);
        semi_next = semi_tmp;
        if (!semi_tmp) begin
          param_next = param_fold;
        end
        mode_next = MODE_BODY;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      param <= '0;
      semi  <= 1'b0;
    end else if (fire) begin
      mode  <= mode_next;
      param <= param_next;
      semi  <= semi_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tkd_out_buf.sv =====
`default_nettype none

module tkd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tkd_pkg::result_t push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tkd_pkg::result_t      out_data
);
  import tkd_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    pop_ok;

  assign push_ready = !skid_valid;
  assign pop_ok     = !out_valid || out_ready;

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop_ok) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload: main register refills from skid first
  always_ff @(posedge clk) begin
    if (pop_ok) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tkd_checker.sv =====
`default_nettype none

module tkd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import tkd_pkg::*;

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // mouse and unknown items carry a zero key code
  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == KIND_MOUSE) || (m_tuser == KIND_UNKNOWN))
      |-> (m_tdata[8:0] == 9'd0))
    else $error("nonzero key code on mouse or unknown item");

  // plain bytes stay within a byte
  a_plain_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_PLAIN) |-> !m_tdata[8])
    else $error("plain key code above one byte");

  // special keycodes come from the tables only
  a_special_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_SPECIAL)
      |-> (m_tdata[8:0] >= 9'd314) && (m_tdata[8:0] <= 9'd389))
    else $error("special key code outside table range");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:9] == 7'd0))
    else $error("tdata padding not zero");

endmodule

bind terminal_escape_key_decoder tkd_checker u_tkd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
